FILE: rtl/core/psd_pkg.sv
// shared widths, types and the divider step for the point to segment distance core
`timescale 1ns / 1ps
package psd_pkg;

  localparam int CW   = 24;              // coordinate width, Q15.8
  localparam int DW   = CW + 1;          // coordinate difference width
  localparam int PW   = 2 * DW;          // product of two differences
  localparam int DOTW = PW + 2;          // signed dot product
  localparam int DDW  = 2 * CW + 2;      // squared length of the line
  localparam int DVW  = DOTW - 1;        // magnitude of the dot product
  localparam int LOW  = (DVW + 1) / 2;   // low slice for the split multiply
  localparam int HIW  = DVW - LOW;
  localparam int NW   = DVW + DW + 1;    // divider dividend width
  localparam int QW   = CW + 3;          // quotient width, bounded by |p - s|
  localparam int WW   = DDW + 1 + QW;    // remainder and quotient shift word
  localparam int DSTW = 2 * CW + 2;      // squared distance width

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [DW-1:0] diff_t;

  typedef struct packed {
    logic          seg;
    coord_t [2:0]  p;
    coord_t [2:0]  s;
    coord_t [2:0]  e;
    diff_t  [2:0]  v;
    diff_t  [2:0]  d;
  } item_t;

  typedef struct packed {
    logic          seg;
    logic          dd_zero;
    logic [2:0]    neg;
    coord_t [2:0]  p;
    coord_t [2:0]  s;
    coord_t [2:0]  e;
  } ctx_t;

  // one restoring division step: shift in the next dividend bit, subtract if it fits
  function automatic logic [WW-1:0] div_step(logic [WW-1:0] w, logic [DDW:0] dv);
    logic [DDW+1:0] t;
    logic [DDW+1:0] r;
    t = w[WW-1:QW-1];
    r = t - {1'b0, dv};
    if (t >= {1'b0, dv}) begin
      return {r[DDW:0], w[QW-2:0], 1'b1};
    end
    return {t[DDW:0], w[QW-2:0], 1'b0};
  endfunction

endpackage

FILE: rtl/core/psd_front.sv
// input stage: registers an item and forms the point and line difference vectors
`timescale 1ns / 1ps
module psd_front import psd_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  logic   command_i,
  input  coord_t point_x_i,
  input  coord_t point_y_i,
  input  coord_t point_z_i,
  input  coord_t start_x_i,
  input  coord_t start_y_i,
  input  coord_t start_z_i,
  input  coord_t end_x_i,
  input  coord_t end_y_i,
  input  coord_t end_z_i,
  output logic   push_valid_o,
  input  logic   push_ready_i,
  output item_t  push_item_o
);

  logic         vld_q;
  logic         seg_q;
  coord_t [2:0] p_q, s_q, e_q;

  assign in_ready_o   = !vld_q || push_ready_i;
  assign push_valid_o = vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      seg_q <= command_i;
      p_q   <= {point_z_i, point_y_i, point_x_i};
      s_q   <= {start_z_i, start_y_i, start_x_i};
      e_q   <= {end_z_i, end_y_i, end_x_i};
    end
  end

  always_comb begin
    push_item_o.seg = seg_q;
    push_item_o.p   = p_q;
    push_item_o.s   = s_q;
    push_item_o.e   = e_q;
    for (int i = 0; i < 3; i++) begin
      push_item_o.v[i] = {p_q[i][CW-1], p_q[i]} - {s_q[i][CW-1], s_q[i]};
      push_item_o.d[i] = {e_q[i][CW-1], e_q[i]} - {s_q[i][CW-1], s_q[i]};
    end
  end

endmodule

FILE: rtl/core/psd_fifo.sv
// two-entry queue between the input stage and the arithmetic pipeline
`timescale 1ns / 1ps
module psd_fifo import psd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  item_t push_item_i,
  output logic  pop_valid_o,
  input  logic  pop_ready_i,
  output item_t pop_item_o
);

  item_t      mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= !wr_q;
      if (pop)  rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

endmodule

FILE: rtl/core/psd_div.sv
// pipelined restoring divider, one quotient bit per stage, three axes side by side
`timescale 1ns / 1ps
module psd_div import psd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  ctx_t                 ctx_i,
  input  logic [2:0][NW-1:0]   num_i,
  input  logic [DDW:0]         den_i,
  output logic                 valid_o,
  output ctx_t                 ctx_o,
  output logic [2:0][QW-1:0]   quo_o
);

  logic [WW-1:0] w_q  [QW][3];
  logic [DDW:0]  dv_q [QW];
  ctx_t          c_q  [QW];
  logic [QW-1:0] vld_q;

  for (genvar k = 0; k < QW; k++) begin : g_st
    logic [WW-1:0] w_in [3];
    logic [DDW:0]  dv_in;
    ctx_t          c_in;
    logic          v_in;

    if (k == 0) begin : g_first
      always_comb begin
        for (int a = 0; a < 3; a++) begin
          w_in[a] = {1'b0, num_i[a]};
        end
      end
      assign dv_in = den_i;
      assign c_in  = ctx_i;
      assign v_in  = valid_i;
    end else begin : g_next
      always_comb begin
        for (int a = 0; a < 3; a++) begin
          w_in[a] = w_q[k-1][a];
        end
      end
      assign dv_in = dv_q[k-1];
      assign c_in  = c_q[k-1];
      assign v_in  = vld_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int a = 0; a < 3; a++) begin
          w_q[k][a] <= div_step(w_in[a], dv_in);
        end
        dv_q[k] <= dv_in;
        c_q[k]  <= c_in;
      end
    end
  end

  assign valid_o = vld_q[QW-1];
  assign ctx_o   = c_q[QW-1];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      quo_o[a] = w_q[QW-1][a][QW-1:0];
    end
  end

endmodule

FILE: rtl/core/psd_back.sv
// arithmetic pipeline: dot products, projection divide, clamp and squared distance
`timescale 1ns / 1ps
module psd_back import psd_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            pop_valid_i,
  output logic            pop_ready_o,
  input  item_t           item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output coord_t          proj_x_o,
  output coord_t          proj_y_o,
  output coord_t          proj_z_o,
  output logic [DSTW-1:0] dist_sq_o
);

  logic       en;
  logic [5:0] fv_q;
  logic [7:0] bv_q;

  assign en          = !bv_q[7] || out_ready_i;
  assign pop_ready_o = en;
  assign out_valid_o = bv_q[7];

  // front half: products, sums, split multiply, dividend
  ctx_t c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;
  ctx_t c3_d;
  logic signed [2:0][PW-1:0]   pvd_q, pdd_q;
  diff_t [2:0]                 d1_q, d2_q;
  logic signed [DOTW-1:0]      dvd_q;
  logic [DDW-1:0]              dd2_q, dd3_q, dd4_q, dd5_q;
  logic [DVW-1:0]              dvmag_q;
  logic [2:0][DW-1:0]          dmag_q;
  logic [2:0][LOW+DW-1:0]      plo_q;
  logic [2:0][HIW+DW-1:0]      phi_q;
  logic [2:0][NW-1:0]          num_q, dvn_q;
  logic [DDW:0]                den_q;

  logic                        dv_valid;
  ctx_t                        dc;
  logic [2:0][QW-1:0]          quo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= '0;
      bv_q <= '0;
    end else if (en) begin
      fv_q <= {fv_q[4:0], pop_valid_i};
      bv_q <= {bv_q[6:0], dv_valid};
    end
  end

  // zero-length flag and quotient signs join the context
  always_comb begin
    c3_d         = c2_q;
    c3_d.dd_zero = (dd2_q == '0);
    for (int i = 0; i < 3; i++) begin
      c3_d.neg[i] = dvd_q[DOTW-1] ^ d2_q[i][DW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // products
      c1_q.seg     <= item_i.seg;
      c1_q.dd_zero <= 1'b0;
      c1_q.neg     <= '0;
      c1_q.p       <= item_i.p;
      c1_q.s       <= item_i.s;
      c1_q.e       <= item_i.e;
      for (int i = 0; i < 3; i++) begin
        pvd_q[i] <= $signed(item_i.v[i]) * $signed(item_i.d[i]);
        pdd_q[i] <= $signed(item_i.d[i]) * $signed(item_i.d[i]);
      end
      d1_q <= item_i.d;
      // sums
      c2_q  <= c1_q;
      d2_q  <= d1_q;
      dvd_q <= DOTW'($signed(pvd_q[0])) + DOTW'($signed(pvd_q[1]))
             + DOTW'($signed(pvd_q[2]));
      dd2_q <= DDW'(pdd_q[0]) + DDW'(pdd_q[1]) + DDW'(pdd_q[2]);
      // magnitudes and quotient signs
      c3_q <= c3_d;
      for (int i = 0; i < 3; i++) begin
        dmag_q[i] <= d2_q[i][DW-1] ? DW'(-d2_q[i]) : DW'(d2_q[i]);
      end
      dvmag_q <= dvd_q[DOTW-1] ? DVW'(-dvd_q) : DVW'(dvd_q);
      dd3_q   <= dd2_q;
      // split multiply
      c4_q  <= c3_q;
      dd4_q <= dd3_q;
      for (int i = 0; i < 3; i++) begin
        plo_q[i] <= dvmag_q[LOW-1:0] * dmag_q[i];
        phi_q[i] <= dvmag_q[DVW-1:LOW] * dmag_q[i];
      end
      // join partial products
      c5_q  <= c4_q;
      dd5_q <= dd4_q;
      for (int i = 0; i < 3; i++) begin
        num_q[i] <= NW'(plo_q[i]) + (NW'(phi_q[i]) << LOW);
      end
      // rounded division operands: (2 num + dd) / (2 dd)
      c6_q  <= c5_q;
      den_q <= {dd5_q, 1'b0};
      for (int i = 0; i < 3; i++) begin
        dvn_q[i] <= {num_q[i][NW-2:0], 1'b0} + NW'(dd5_q);
      end
    end
  end

  psd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fv_q[5]),
    .ctx_i   (c6_q),
    .num_i   (dvn_q),
    .den_i   (den_q),
    .valid_o (dv_valid),
    .ctx_o   (dc),
    .quo_o   (quo)
  );

  // back half: offset, saturate, clamp, distance
  ctx_t p1_q, p2_q, p3_q, p4_q, p5_q;
  logic signed [2:0][QW:0]     off_q;
  coord_t [2:0]                pr2_q, pr3_q, pr4_q, prf_q;
  // projection travels alongside the distance terms
  coord_t [2:0]                prf5_q, prf6_q;
  diff_t  [2:0]                ds_q, de_q, t_q;
  logic [2:0]                  beyond_q, near_q;
  logic [2:0][PW-1:0]          sq_q;
  coord_t [2:0]                proj_q;
  logic [DSTW-1:0]             dist_q;

  logic signed [QW+1:0]        sum [3];
  coord_t [2:0]                pr_sat;
  coord_t [2:0]                pr_sel;
  logic [2:0][DW-1:0]          ads, ade;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i] = (QW+2)'($signed(p1_q.s[i])) + (QW+2)'($signed(off_q[i]));
      // out of range when the sign bit and the bits above it disagree
      if (sum[i][QW+1:CW-1] != '0 && sum[i][QW+1:CW-1] != '1) begin
        pr_sat[i] = sum[i][QW+1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end else begin
        pr_sat[i] = sum[i][CW-1:0];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ads[i] = ds_q[i][DW-1] ? DW'(-ds_q[i]) : DW'(ds_q[i]);
      ade[i] = de_q[i][DW-1] ? DW'(-de_q[i]) : DW'(de_q[i]);
    end
  end

  always_comb begin
    pr_sel = pr4_q;
    if (p4_q.seg) begin
      if (beyond_q[0]) begin
        pr_sel = near_q[0] ? p4_q.s : p4_q.e;
      end else if (beyond_q[1]) begin
        pr_sel = near_q[1] ? p4_q.s : p4_q.e;
      end else if (beyond_q[2]) begin
        pr_sel = near_q[2] ? p4_q.s : p4_q.e;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q <= dc;
      for (int i = 0; i < 3; i++) begin
        if (dc.dd_zero) begin
          off_q[i] <= '0;
        end else if (dc.neg[i]) begin
          off_q[i] <= -$signed({1'b0, quo[i]});
        end else begin
          off_q[i] <= $signed({1'b0, quo[i]});
        end
      end
      p2_q  <= p1_q;
      pr2_q <= pr_sat;
      p3_q  <= p2_q;
      pr3_q <= pr2_q;
      for (int i = 0; i < 3; i++) begin
        ds_q[i] <= {pr2_q[i][CW-1], pr2_q[i]} - {p2_q.s[i][CW-1], p2_q.s[i]};
        de_q[i] <= {pr2_q[i][CW-1], pr2_q[i]} - {p2_q.e[i][CW-1], p2_q.e[i]};
      end
      p4_q  <= p3_q;
      pr4_q <= pr3_q;
      for (int i = 0; i < 3; i++) begin
        beyond_q[i] <= (!ds_q[i][DW-1] && ds_q[i] != '0 && !de_q[i][DW-1] && de_q[i] != '0)
                    || (ds_q[i][DW-1] && de_q[i][DW-1]);
        near_q[i]   <= ads[i] < ade[i];
      end
      p5_q  <= p4_q;
      prf_q <= pr_sel;
      prf5_q <= prf_q;
      for (int i = 0; i < 3; i++) begin
        t_q[i] <= {p5_q.p[i][CW-1], p5_q.p[i]} - {prf_q[i][CW-1], prf_q[i]};
      end
      prf6_q <= prf5_q;
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= $signed(t_q[i]) * $signed(t_q[i]);
      end
      proj_q <= prf6_q;
      dist_q <= DSTW'(sq_q[0]) + DSTW'(sq_q[1]) + DSTW'(sq_q[2]);
    end
  end

  assign proj_x_o  = proj_q[0];
  assign proj_y_o  = proj_q[1];
  assign proj_z_o  = proj_q[2];
  assign dist_sq_o = dist_q;

endmodule

FILE: rtl/core/point_segment_distance_squared_core.sv
// top level of the point to line or segment squared distance core
//
//   channel  signals                                   direction  handshake
//   in       command, point_*, start_*, end_*          input      in_valid_i / in_ready_o
//   out      proj_x, proj_y, proj_z, dist_sq           output     out_valid_o / out_ready_i
//
// one item per cycle sustained while out_ready_i accepts results; the path includes
// the 27-stage divider pipeline that yields one quotient bit per stage
// reset clears only valid bits and queue pointers; the core keeps no state
// the arithmetic pipeline freezes as a whole while a result waits at the output,
// and the input stage plus the two-entry queue take up to three more items meanwhile
`timescale 1ns / 1ps
module point_segment_distance_squared_core import psd_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            command_i,
  input  coord_t          point_x_i,
  input  coord_t          point_y_i,
  input  coord_t          point_z_i,
  input  coord_t          start_x_i,
  input  coord_t          start_y_i,
  input  coord_t          start_z_i,
  input  coord_t          end_x_i,
  input  coord_t          end_y_i,
  input  coord_t          end_z_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output coord_t          proj_x_o,
  output coord_t          proj_y_o,
  output coord_t          proj_z_o,
  output logic [DSTW-1:0] dist_sq_o
);

  logic  push_valid, push_ready, pop_valid, pop_ready;
  item_t push_item, pop_item;

  psd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .point_z_i    (point_z_i),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .start_z_i    (start_z_i),
    .end_x_i      (end_x_i),
    .end_y_i      (end_y_i),
    .end_z_i      (end_z_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  psd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  psd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .item_i      (pop_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .proj_x_o    (proj_x_o),
    .proj_y_o    (proj_y_o),
    .proj_z_o    (proj_z_o),
    .dist_sq_o   (dist_sq_o)
  );

endmodule
